@@ rtl/core/vcsr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsr_pkg: shared types and constants
// Constants, config and command/status types shared by the stencil residual
// controller, datapath and top level.
// ----------------------------------------------------------------------------
package vcsr_pkg;

  // fixed number formats
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int CNT_W     = 11;
  localparam int ROW_W     = 16;
  localparam int MAG_W     = 52;

  // divider: quotient bits per cycle and step count for a 32-bit quotient
  localparam int DIV_RADIX = 2;
  localparam int DIV_STEPS = 32 / DIV_RADIX;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // register indexes
  localparam logic [2:0] REG_GRID_WIDTH    = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_INV_DX_SQ     = 3'd2;
  localparam logic [2:0] REG_INV_DY_SQ     = 3'd3;
  localparam logic [2:0] REG_BOUNDARY_MODE = 3'd4;
  localparam logic [2:0] REG_RESIDUAL_MODE = 3'd5;

  // boundary modes
  localparam logic [1:0] BND_DIRICHLET = 2'd0;
  localparam logic [1:0] BND_NEUMANN   = 2'd1;

  // operand selects for harmonic and scaled-product steps
  localparam logic [2:0] OP_EAST  = 3'd0;
  localparam logic [2:0] OP_WEST  = 3'd1;
  localparam logic [2:0] OP_NORTH = 3'd2;
  localparam logic [2:0] OP_SOUTH = 3'd3;
  localparam logic [2:0] OP_X     = 3'd4;
  localparam logic [2:0] OP_Y     = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_C,
    ST_RD_E,
    ST_RD_W,
    ST_RD_S,
    ST_RD_WAIT,
    ST_H_MUL,
    ST_H_DINIT,
    ST_H_DIV,
    ST_H_STORE,
    ST_MS_PREP,
    ST_MS_LO,
    ST_MS_HI,
    ST_MS_FIN,
    ST_SUM,
    ST_EMIT_UP,
    ST_WRITE,
    ST_EMIT_LAST
  } vcsr_state_t;

  typedef enum logic [1:0] {
    TAG_C,
    TAG_E,
    TAG_W,
    TAG_S
  } vcsr_tag_t;

  typedef struct packed {
    logic [CNT_W-1:0] grid_width;
    logic [ROW_W-1:0] grid_height;
    logic [31:0]      inv_dx_sq;
    logic [31:0]      inv_dy_sq;
    logic [1:0]       boundary_mode;
    logic             residual_mode;
  } vcsr_cfg_t;

  typedef struct packed {
    logic      load;
    logic      rd_en;
    vcsr_tag_t rd_sel;
    logic      h_mul;
    logic      div_init;
    logic      div_step;
    logic      h_store;
    logic      ms_prep;
    logic      ms_lo;
    logic      ms_hi;
    logic      ms_fin;
    logic [2:0] op;
    logic      sum;
    logic      emit_up;
    logic      emit_last;
    logic      write;
  } vcsr_cmd_t;

  typedef struct packed {
    logic has_up;
    logic compute;
    logic last_row;
    logic div_last;
    logic out_free;
  } vcsr_sts_t;

endpackage

@@ rtl/core/vcsr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsr_ctrl: stencil residual sequencer
// State machine that steps one item through row reads, four harmonic averages
// and six scaled products for interior cells, emission and the row store write.
// ----------------------------------------------------------------------------
module vcsr_ctrl
  import vcsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  vcsr_sts_t sts,
  output vcsr_cmd_t cmd
);

  vcsr_state_t state_r, state_nxt;
  logic [2:0]  op_cnt_r, op_cnt_nxt;

  // state and operand counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      op_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      op_cnt_r <= op_cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    op_cnt_nxt = op_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RD_C;
      end
      ST_RD_C:  state_nxt = ST_RD_E;
      ST_RD_E:  state_nxt = ST_RD_W;
      ST_RD_W:  state_nxt = ST_RD_S;
      ST_RD_S:  state_nxt = ST_RD_WAIT;
      ST_RD_WAIT: begin
        op_cnt_nxt = '0;
        if (!sts.has_up) state_nxt = ST_WRITE;
        else if (sts.compute) state_nxt = ST_H_MUL;
        else state_nxt = ST_SUM;
      end
      ST_H_MUL:   state_nxt = ST_H_DINIT;
      ST_H_DINIT: state_nxt = ST_H_DIV;
      ST_H_DIV: begin
        if (sts.div_last) state_nxt = ST_H_STORE;
      end
      ST_H_STORE: begin
        if (op_cnt_r == OP_SOUTH) begin
          op_cnt_nxt = '0;
          state_nxt  = ST_MS_PREP;
        end else begin
          op_cnt_nxt = op_cnt_r + 3'd1;
          state_nxt  = ST_H_MUL;
        end
      end
      ST_MS_PREP: state_nxt = ST_MS_LO;
      ST_MS_LO:   state_nxt = ST_MS_HI;
      ST_MS_HI:   state_nxt = ST_MS_FIN;
      ST_MS_FIN: begin
        op_cnt_nxt = op_cnt_r + 3'd1;
        if (op_cnt_r == OP_Y) state_nxt = ST_SUM;
        else state_nxt = ST_MS_PREP;
      end
      ST_SUM: state_nxt = ST_EMIT_UP;
      ST_EMIT_UP: begin
        if (sts.out_free) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (sts.last_row) state_nxt = ST_EMIT_LAST;
        else state_nxt = ST_IDLE;
      end
      ST_EMIT_LAST: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd      = '0;
    cmd.op   = op_cnt_r;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RD_C: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = TAG_C;
      end
      ST_RD_E: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = TAG_E;
      end
      ST_RD_W: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = TAG_W;
      end
      ST_RD_S: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = TAG_S;
      end
      ST_H_MUL:     cmd.h_mul    = 1'b1;
      ST_H_DINIT:   cmd.div_init = 1'b1;
      ST_H_DIV:     cmd.div_step = 1'b1;
      ST_H_STORE:   cmd.h_store  = 1'b1;
      ST_MS_PREP:   cmd.ms_prep  = 1'b1;
      ST_MS_LO:     cmd.ms_lo    = 1'b1;
      ST_MS_HI:     cmd.ms_hi    = 1'b1;
      ST_MS_FIN:    cmd.ms_fin   = 1'b1;
      ST_SUM:       cmd.sum      = 1'b1;
      ST_EMIT_UP:   cmd.emit_up  = sts.out_free;
      ST_WRITE:     cmd.write    = 1'b1;
      ST_EMIT_LAST: cmd.emit_last = sts.out_free;
      default: ;
    endcase
  end

endmodule

@@ rtl/core/vcsr_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsr_dpath: stencil residual datapath
// Row stores, position counters, shared harmonic-average divider, shared
// scaled-product multiplier, saturation and the output register.
// ----------------------------------------------------------------------------
module vcsr_dpath
  import vcsr_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vcsr_cfg_t          cfg,
  input  vcsr_cmd_t          cmd,
  output vcsr_sts_t          sts,
  input  logic signed [31:0] in_potential,
  input  logic [31:0]        in_inv_permeability,
  input  logic signed [31:0] in_source_current,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] out_result_value,
  output logic [9:0]         out_column,
  output logic [15:0]        out_row,
  output logic               out_grid_done
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int DEPTH = 2 * MAX_WIDTH;
  localparam logic [AW:0]  ROW1_BASE   = (AW+1)'(MAX_WIDTH);
  localparam logic [64:0]  LO_ROUND    = (65'd1 << FRAC_BITS) - 65'd1;
  localparam logic [63:0]  TERM_LIMIT  = 64'd1 << 61;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  function automatic logic signed [63:0] sx(input logic [31:0] v);
    sx = {{32{v[31]}}, v};
  endfunction

  // ---- row stores ----
  logic [31:0] pot_mem  [DEPTH];
  logic [31:0] perm_mem [DEPTH];
  logic [31:0] src_mem  [MAX_WIDTH];
  logic [31:0] pot_q_r, perm_q_r, src_q_r;
  logic        rd_vld_r;
  vcsr_tag_t   rd_tag_r;

  // ---- latched item and position ----
  logic [31:0]      in_pot_r, in_nu_r, in_src_r;
  logic [CNT_W-1:0] c_r, col_cnt_r;
  logic [ROW_W-1:0] r_r, row_cnt_r;
  logic small_r, has_up_r, interior_r, last_row_r, last_col_r;
  logic mir_e_r, mir_w_r, mir_n_r, mir_s_r;

  // ---- neighbour values ----
  logic [31:0] xc_r, xe_r, xw_r, xs_r, np_r, pe_r, pw_r, ps_r, csrc_r;

  // ---- harmonic unit ----
  logic [63:0]       prod_r;
  logic [32:0]       sum_r;
  logic [32:0]       rem_r, rem_nxt, rem_t;
  logic [33:0]       rem_sh;
  logic [31:0]       dq_r, dq_nxt, dq_t;
  logic [STEP_W-1:0] step_cnt_r;
  logic [31:0]       h_r [4];
  logic [31:0]       h_other;

  // ---- scaled-product unit ----
  logic signed [63:0] s_sel, s_abs;
  logic [31:0]        u_sel, u_r;
  logic               neg_r;
  logic [MAG_W-1:0]   m_r;
  logic [63:0]        lo_r;
  logic [MAG_W-1:0]   hi_r;
  logic [64:0]        lo_ext, lo_sh;
  logic               hi_over;
  logic [63:0]        mag_sum, mag;
  logic signed [63:0] term;
  logic signed [63:0] t_r [6];
  logic [31:0]        xe_eff, xw_eff, xn_eff, xs_eff;

  // ---- result ----
  logic signed [63:0] val_r, fin_v, fin_s, fin_d, fin_sat;
  logic               out_valid_r, out_done_r;
  logic [31:0]        out_val_r;
  logic [9:0]         out_col_r;
  logic [15:0]        out_row_r;

  // ---- geometry ----
  logic [CNT_W-1:0] w_eff, c_ld, c_inc;
  logic [ROW_W-1:0] h_eff, r_ld;
  logic             oor;
  logic [AW-1:0]    c_idx, c_e_idx, c_w_idx;
  logic [AW:0]      prv_base, cur_base, rd_addr, wr_addr;

  // effective grid size
  always_comb begin
    if (cfg.grid_width == '0) w_eff = CNT_W'(1);
    else if (int'(cfg.grid_width) > MAX_WIDTH) w_eff = CNT_W'(MAX_WIDTH);
    else w_eff = cfg.grid_width;
    h_eff = (cfg.grid_height == '0) ? ROW_W'(1) : cfg.grid_height;
  end

  // position of the arriving item, restarted when out of range
  assign oor  = (row_cnt_r >= h_eff) || (col_cnt_r >= w_eff);
  assign c_ld = oor ? '0 : col_cnt_r;
  assign r_ld = oor ? '0 : row_cnt_r;

  // item latch and position flags
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_pot_r   <= in_potential;
      in_nu_r    <= in_inv_permeability;
      in_src_r   <= in_source_current;
      c_r        <= c_ld;
      r_r        <= r_ld;
      small_r    <= (w_eff < CNT_W'(3)) || (h_eff < ROW_W'(3));
      has_up_r   <= (r_ld != '0);
      interior_r <= (r_ld >= ROW_W'(2)) && (c_ld != '0) &&
                    ({1'b0, c_ld} + 12'd2 <= {1'b0, w_eff});
      last_row_r <= ({1'b0, r_ld} + 17'd1 == {1'b0, h_eff});
      last_col_r <= ({1'b0, c_ld} + 12'd1 == {1'b0, w_eff});
      mir_w_r    <= (cfg.boundary_mode == BND_NEUMANN) && (c_ld == CNT_W'(1));
      mir_e_r    <= (cfg.boundary_mode == BND_NEUMANN) &&
                    ({1'b0, c_ld} + 12'd2 == {1'b0, w_eff});
      mir_s_r    <= (cfg.boundary_mode == BND_NEUMANN) && (r_ld == ROW_W'(2));
      mir_n_r    <= (cfg.boundary_mode == BND_NEUMANN) &&
                    ({1'b0, r_ld} + 17'd1 == {1'b0, h_eff});
    end
  end

  // raster counters, advanced when the item is stored
  assign c_inc = c_r + CNT_W'(1);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (cmd.write) begin
      if (last_col_r) begin
        col_cnt_r <= '0;
        row_cnt_r <= last_row_r ? '0 : r_r + ROW_W'(1);
      end else begin
        col_cnt_r <= c_inc;
      end
    end
  end

  // row store addressing: row parity picks the half
  assign c_idx    = AW'(c_r);
  assign c_e_idx  = AW'(c_inc);
  assign c_w_idx  = AW'(c_r - CNT_W'(1));
  assign prv_base = r_r[0] ? '0 : ROW1_BASE;
  assign cur_base = r_r[0] ? ROW1_BASE : '0;
  assign wr_addr  = cur_base + {1'b0, c_idx};

  always_comb begin
    case (cmd.rd_sel)
      TAG_C:   rd_addr = prv_base + {1'b0, c_idx};
      TAG_E:   rd_addr = prv_base + {1'b0, c_e_idx};
      TAG_W:   rd_addr = prv_base + {1'b0, c_w_idx};
      default: rd_addr = cur_base + {1'b0, c_idx};
    endcase
  end

  // row stores, one read or one write per cycle
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      pot_mem[wr_addr]  <= in_pot_r;
      perm_mem[wr_addr] <= in_nu_r;
      src_mem[c_idx]    <= in_src_r;
    end
    if (cmd.rd_en) begin
      pot_q_r  <= pot_mem[rd_addr];
      perm_q_r <= perm_mem[rd_addr];
      src_q_r  <= src_mem[c_idx];
    end
  end

  // read tag follows the read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      rd_tag_r <= TAG_C;
    end else begin
      rd_vld_r <= cmd.rd_en;
      rd_tag_r <= cmd.rd_sel;
    end
  end

  // capture neighbours
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      case (rd_tag_r)
        TAG_C: begin
          xc_r   <= pot_q_r;
          np_r   <= perm_q_r;
          csrc_r <= src_q_r;
        end
        TAG_E: begin
          xe_r <= pot_q_r;
          pe_r <= perm_q_r;
        end
        TAG_W: begin
          xw_r <= pot_q_r;
          pw_r <= perm_q_r;
        end
        default: begin
          xs_r <= pot_q_r;
          ps_r <= perm_q_r;
        end
      endcase
    end
  end

  // harmonic operand select
  always_comb begin
    case (cmd.op)
      OP_EAST:  h_other = pe_r;
      OP_WEST:  h_other = pw_r;
      OP_NORTH: h_other = in_nu_r;
      default:  h_other = ps_r;
    endcase
  end

  // restoring divider, DIV_RADIX quotient bits per step
  always_comb begin
    rem_t  = rem_r;
    dq_t   = dq_r;
    rem_sh = '0;
    for (int j = 0; j < DIV_RADIX; j++) begin
      rem_sh = {rem_t, dq_t[31]};
      dq_t   = {dq_t[30:0], 1'b0};
      if (rem_sh >= {1'b0, sum_r}) begin
        rem_sh  = rem_sh - {1'b0, sum_r};
        dq_t[0] = 1'b1;
      end
      rem_t = rem_sh[32:0];
    end
    rem_nxt = rem_t;
    dq_nxt  = dq_t;
  end

  // harmonic average 2ab/(a+b): product, then divide the doubled product
  always_ff @(posedge clk) begin
    if (cmd.h_mul) begin
      prod_r <= np_r * h_other;
      sum_r  <= {1'b0, np_r} + {1'b0, h_other};
    end
    if (cmd.div_init) begin
      rem_r <= prod_r[63:31];
      dq_r  <= {prod_r[30:0], 1'b0};
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
    if (cmd.h_store) h_r[cmd.op[1:0]] <= (sum_r == '0) ? '0 : dq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) step_cnt_r <= '0;
    else if (cmd.div_init) step_cnt_r <= '0;
    else if (cmd.div_step) step_cnt_r <= step_cnt_r + STEP_W'(1);
  end

  // neumann mirror of border neighbours
  assign xe_eff = mir_e_r ? xc_r : xe_r;
  assign xw_eff = mir_w_r ? xc_r : xw_r;
  assign xn_eff = mir_n_r ? xc_r : in_pot_r;
  assign xs_eff = mir_s_r ? xc_r : xs_r;

  // scaled-product operand select
  always_comb begin
    case (cmd.op)
      OP_EAST: begin
        s_sel = sx(xe_eff) - sx(xc_r);
        u_sel = h_r[0];
      end
      OP_WEST: begin
        s_sel = sx(xc_r) - sx(xw_eff);
        u_sel = h_r[1];
      end
      OP_NORTH: begin
        s_sel = sx(xn_eff) - sx(xc_r);
        u_sel = h_r[2];
      end
      OP_SOUTH: begin
        s_sel = sx(xc_r) - sx(xs_eff);
        u_sel = h_r[3];
      end
      OP_X: begin
        s_sel = t_r[0] - t_r[1];
        u_sel = cfg.inv_dx_sq;
      end
      default: begin
        s_sel = t_r[2] - t_r[3];
        u_sel = cfg.inv_dy_sq;
      end
    endcase
    s_abs = s_sel[63] ? -s_sel : s_sel;
  end

  // floor of the product shifted by FRAC_BITS, clamped
  always_comb begin
    lo_ext  = {1'b0, lo_r} + (neg_r ? LO_ROUND : 65'd0);
    lo_sh   = lo_ext >> FRAC_BITS;
    hi_over = (hi_r >> (29 + FRAC_BITS)) != '0;
    mag_sum = (64'(hi_r) << (32 - FRAC_BITS)) + lo_sh[63:0];
    mag     = (hi_over || (mag_sum > TERM_LIMIT)) ? TERM_LIMIT : mag_sum;
    term    = neg_r ? -$signed(mag) : $signed(mag);
  end

  // scaled product: sign/magnitude, low and high partial products, combine
  always_ff @(posedge clk) begin
    if (cmd.ms_prep) begin
      neg_r <= s_sel[63];
      m_r   <= s_abs[MAG_W-1:0];
      u_r   <= u_sel;
    end
    if (cmd.ms_lo) lo_r <= m_r[31:0] * u_r;
    if (cmd.ms_hi) hi_r <= m_r[MAG_W-1:32] * u_r;
    if (cmd.ms_fin) t_r[cmd.op] <= term;
  end

  // operator value for the upper-row cell
  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      if (small_r) val_r <= '0;
      else if (interior_r) val_r <= -(t_r[4] + t_r[5]);
      else if (cfg.boundary_mode == BND_DIRICHLET) val_r <= sx(xc_r);
      else val_r <= '0;
    end
  end

  // residual and saturation
  always_comb begin
    if (cmd.emit_last) begin
      fin_v = (!small_r && (cfg.boundary_mode == BND_DIRICHLET)) ? sx(in_pot_r) : '0;
      fin_s = sx(in_src_r);
    end else begin
      fin_v = val_r;
      fin_s = sx(csrc_r);
    end
    fin_d = cfg.residual_mode ? fin_v - fin_s : fin_v;
    if (fin_d > SAT_HI) fin_sat = SAT_HI;
    else if (fin_d < SAT_LO) fin_sat = SAT_LO;
    else fin_sat = fin_d;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit_up || cmd.emit_last) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_up || cmd.emit_last) begin
      out_val_r  <= fin_sat[DATA_W-1:0];
      out_col_r  <= c_r[9:0];
      out_row_r  <= cmd.emit_last ? r_r : r_r - ROW_W'(1);
      out_done_r <= cmd.emit_last && last_col_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_val_r;
  assign out_column       = out_col_r;
  assign out_row          = out_row_r;
  assign out_grid_done    = out_done_r;

  // status to the sequencer
  assign sts.has_up   = has_up_r;
  assign sts.compute  = interior_r && !small_r;
  assign sts.last_row = last_row_r;
  assign sts.div_last = (step_cnt_r == STEP_W'(DIV_STEPS - 1));
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

@@ rtl/core/variable_coeff_stencil_residual_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_coeff_stencil_residual_unit: five-point variable-coefficient stencil
// Streams grid cells in raster order and returns the negated flux (or the
// residual) of each cell one row later, with saturated Q16.16 results.
//
// channel  direction  handshake             payload
// in_      input      in_valid / in_ready   potential, inv_permeability, source
// out_     output     out_valid / out_ready value, column, row, grid_done
// cfg_     input      cfg_write_en          cfg_index, cfg_data
//
// One item at a time. A cell whose upper neighbour row is interior runs
// four harmonic averages on the shared 2-bit-per-cycle divider and six
// scaled products on the shared multiplier; other cells skip them.
// Reset sets config to its defaults and clears counters and output valid;
// row stores are not cleared. A stalled output holds the sequencer in its emit state until taken.
// ----------------------------------------------------------------------------
module variable_coeff_stencil_residual_unit
  import vcsr_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_potential,
  input  logic [31:0]        in_inv_permeability,
  input  logic signed [31:0] in_source_current,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic [9:0]         out_column,
  output logic [15:0]        out_row,
  output logic               out_grid_done,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  vcsr_cfg_t cfg_r;
  vcsr_cmd_t cmd;
  vcsr_sts_t sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width    <= CNT_W'(1);
      cfg_r.grid_height   <= ROW_W'(1);
      cfg_r.inv_dx_sq     <= 32'd65536;
      cfg_r.inv_dy_sq     <= 32'd65536;
      cfg_r.boundary_mode <= BND_DIRICHLET;
      cfg_r.residual_mode <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_GRID_WIDTH:    cfg_r.grid_width    <= cfg_data[CNT_W-1:0];
        REG_GRID_HEIGHT:   cfg_r.grid_height   <= cfg_data[ROW_W-1:0];
        REG_INV_DX_SQ:     cfg_r.inv_dx_sq     <= cfg_data;
        REG_INV_DY_SQ:     cfg_r.inv_dy_sq     <= cfg_data;
        REG_BOUNDARY_MODE: cfg_r.boundary_mode <= cfg_data[1:0];
        REG_RESIDUAL_MODE: cfg_r.residual_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  vcsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  vcsr_dpath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_potential        (in_potential),
    .in_inv_permeability (in_inv_permeability),
    .in_source_current   (in_source_current),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_result_value    (out_result_value),
    .out_column          (out_column),
    .out_row             (out_row),
    .out_grid_done       (out_grid_done)
  );

endmodule

@@ rtl/core/vcsr_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsr_chk: port-level checks
// Observes the top-level ports of the stencil residual unit over time.
// ----------------------------------------------------------------------------
module vcsr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_value,
  input logic        out_grid_done
);

  // one item at a time: ready drops after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item was in progress");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value) &&
      $stable(out_grid_done))
    else $error("stalled result changed or dropped");

  // results are loaded only while the input side is closed
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the unit was idle");

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind variable_coeff_stencil_residual_unit vcsr_chk u_vcsr_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_value (out_result_value),
  .out_grid_done    (out_grid_done)
);

@@ bench/variable_coeff_stencil_residual_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_coeff_stencil_residual_unit_tb: self-checking bench for the stencil
// Feeds grids, capped in cell count, under several register settings and idle
// patterns. Every cell accepted is run through a local model of the stencil.
// Each result item is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module variable_coeff_stencil_residual_unit_tb;
  import vcsr_pkg::*;

  localparam int          BUF_W       = 1024;
  localparam logic [1:0]  BND_OPEN    = 2'd2;
  localparam logic [1:0]  BND_SPARE   = 2'd3;
  localparam int          DRAIN_WAIT  = 300;
  localparam int          STALL_LIMIT = 50000;
  localparam int          PHASE_CELLS = 150;
  localparam longint unsigned TERM_LIMIT = 64'h1 << 61;

  typedef struct packed {
    logic [31:0] value;
    logic [9:0]  column;
    logic [15:0] row;
    logic        done;
  } cell_result_t;

  typedef struct {
    logic [31:0]  pot;
    logic [31:0]  nu;
    logic [31:0]  src;
    bit           typed;
    cell_result_t want;
  } cell_row_t;

  typedef struct {
    int unsigned w;
    int unsigned h;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [1:0]  bnd;
    bit          res;
    int          grids;
  } grid_setup_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_potential = '0;
  logic [31:0]        in_inv_permeability = '0;
  logic signed [31:0] in_source_current = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_result_value;
  logic [9:0]         out_column;
  logic [15:0]        out_row;
  logic               out_grid_done;
  logic               cfg_write_en = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  variable_coeff_stencil_residual_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_potential        (in_potential),
    .in_inv_permeability (in_inv_permeability),
    .in_source_current   (in_source_current),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_value    (out_result_value),
    .out_column          (out_column),
    .out_row             (out_row),
    .out_grid_done       (out_grid_done),
    .cfg_write_en        (cfg_write_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #1 clk = ~clk;

  // local copy of the registers and the row stores
  logic [10:0] m_width = 11'd1;
  logic [15:0] m_height = 16'd1;
  logic [31:0] m_dx = 32'd65536;
  logic [31:0] m_dy = 32'd65536;
  logic [1:0]  m_bnd = BND_DIRICHLET;
  logic        m_res = 1'b0;
  logic [31:0] pot_store [2*BUF_W];
  logic [31:0] perm_store [2*BUF_W];
  logic [31:0] src_store [BUF_W];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  cell_result_t pending_results [$];
  cell_result_t fresh_results [$];
  int           cells_taken = 0;
  int           errors = 0;
  int           idle_cycles = 0;
  int           gap_pct = 0;
  int           stall_pct = 0;
  bit           drv_typed = 1'b0;
  cell_result_t drv_want;

  function automatic longint sx32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // face coefficient 2ab/(a+b), zero when both are zero
  function automatic logic [31:0] face_coeff(logic [31:0] a, logic [31:0] b);
    longint unsigned sum, prod, q, rem;
    sum = {32'b0, a} + {32'b0, b};
    if (sum == 0) return '0;
    prod = {32'b0, a} * {32'b0, b};
    q = prod / sum;
    rem = prod % sum;
    return 32'(2 * q + (2 * rem) / sum);
  endfunction

  // floor(s*u >> 16), magnitude clamped to 2^61
  function automatic longint scale_floor(longint s, logic [31:0] u);
    bit neg;
    longint unsigned m, hi, lo, mag;
    neg = s < 0;
    m = neg ? 64'd0 - longint'(s) : longint'(s);
    hi = (m >> 32) * {32'b0, u};
    lo = (m & 64'hFFFF_FFFF) * {32'b0, u};
    if (neg) lo = (lo + ((64'd1 << FRAC_BITS) - 1)) >> FRAC_BITS;
    else lo = lo >> FRAC_BITS;
    if ((hi >> (29 + FRAC_BITS)) != 0) begin
      mag = TERM_LIMIT;
    end else begin
      mag = (hi << (32 - FRAC_BITS)) + lo;
      if (mag > TERM_LIMIT) mag = TERM_LIMIT;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic [31:0] saturate_out(longint v, longint src);
    if (m_res) v = v - src;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // stencil prediction for one accepted cell, results into fresh_results
  task automatic stencil_predict(logic [31:0] pot, logic [31:0] nu, logic [31:0] src);
    int unsigned w, h, r, c, cur, prv, cr;
    bit tiny;
    longint xc, xe, xw, xn, xs, sxv, syv, val;
    logic [31:0] np, ne, nw, nn, ns;
    cell_result_t res;
    w = m_width;
    if (w == 0) w = 1;
    if (w > BUF_W) w = BUF_W;
    h = m_height;
    if (h == 0) h = 1;
    tiny = (w < 3) || (h < 3);
    r = row_pos;
    c = col_pos;
    if (r >= h || c >= w) begin
      r = 0;
      c = 0;
    end
    cur = (r & 1) * BUF_W;
    prv = ((r & 1) ^ 1) * BUF_W;
    fresh_results.delete();
    // upper row cell finishes now that its north neighbour is here
    if (r >= 1) begin
      cr = r - 1;
      xc = sx32(pot_store[prv+c]);
      if (tiny) begin
        val = 0;
      end else if (cr >= 1 && cr + 2 <= h && c >= 1 && c + 2 <= w) begin
        np = perm_store[prv+c];
        ne = face_coeff(np, perm_store[prv+c+1]);
        nw = face_coeff(np, perm_store[prv+c-1]);
        nn = face_coeff(np, nu);
        ns = face_coeff(np, perm_store[cur+c]);
        xe = sx32(pot_store[prv+c+1]);
        xw = sx32(pot_store[prv+c-1]);
        xn = sx32(pot);
        xs = sx32(pot_store[cur+c]);
        if (m_bnd == BND_NEUMANN) begin
          if (c == 1) xw = xc;
          if (c + 2 == w) xe = xc;
          if (cr == 1) xs = xc;
          if (cr + 2 == h) xn = xc;
        end
        sxv = scale_floor(xe - xc, ne) - scale_floor(xc - xw, nw);
        syv = scale_floor(xn - xc, nn) - scale_floor(xc - xs, ns);
        val = -(scale_floor(sxv, m_dx) + scale_floor(syv, m_dy));
      end else begin
        val = (m_bnd == BND_DIRICHLET) ? xc : 0;
      end
      res.value = saturate_out(val, sx32(src_store[c]));
      res.column = c[9:0];
      res.row = cr[15:0];
      res.done = 1'b0;
      fresh_results.push_back(res);
    end
    pot_store[cur+c] = pot;
    perm_store[cur+c] = nu;
    src_store[c] = src;
    // last row cells also emit on arrival
    if (r + 1 == h) begin
      val = (!tiny && m_bnd == BND_DIRICHLET) ? sx32(pot) : 0;
      res.value = saturate_out(val, sx32(src));
      res.column = c[9:0];
      res.row = r[15:0];
      res.done = (c + 1 == w);
      fresh_results.push_back(res);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  // result check first, then predictions for the cell taken at this edge
  always @(posedge clk) begin
    cell_result_t got, exp_r;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_result_value, out_column, out_row, out_grid_done};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item value %h col %0d row %0d done %0b",
                 $time, got.value, got.column, got.row, got.done);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.value !== exp_r.value) begin
          $display("%0t: value expected %h actual %h", $time, exp_r.value, got.value);
          errors++;
        end
        if (got.column !== exp_r.column) begin
          $display("%0t: column expected %0d actual %0d", $time, exp_r.column, got.column);
          errors++;
        end
        if (got.row !== exp_r.row) begin
          $display("%0t: row expected %0d actual %0d", $time, exp_r.row, got.row);
          errors++;
        end
        if (got.done !== exp_r.done) begin
          $display("%0t: grid_done expected %0b actual %0b", $time, exp_r.done, got.done);
          errors++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      stencil_predict(in_potential, in_inv_permeability, in_source_current);
      if (drv_typed) pending_results.push_back(drv_want);
      else foreach (fresh_results[k]) pending_results.push_back(fresh_results[k]);
      cells_taken++;
    end
  end

  // watchdog on cycles without an accepted item, a register write or reset
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // register write, called at a falling edge, returns at the next one
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_write_en = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      REG_GRID_WIDTH:    m_width = data[10:0];
      REG_GRID_HEIGHT:   m_height = data[15:0];
      REG_INV_DX_SQ:     m_dx = data;
      REG_INV_DY_SQ:     m_dy = data;
      REG_BOUNDARY_MODE: m_bnd = data[1:0];
      REG_RESIDUAL_MODE: m_res = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  task automatic apply_setup(grid_setup_t g);
    write_reg(REG_GRID_WIDTH, g.w);
    write_reg(REG_GRID_HEIGHT, g.h);
    write_reg(REG_INV_DX_SQ, g.dx);
    write_reg(REG_INV_DY_SQ, g.dy);
    write_reg(REG_BOUNDARY_MODE, {30'b0, g.bnd});
    write_reg(REG_RESIDUAL_MODE, {31'b0, g.res});
  endtask

  // hold until every expected result is out and the block has settled
  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // present one cell and hold it until accepted
  task automatic send_cell(logic [31:0] pot, logic [31:0] nu, logic [31:0] src,
                           bit typed, cell_result_t want);
    int seen;
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_potential = pot;
    in_inv_permeability = nu;
    in_source_current = src;
    drv_typed = typed;
    drv_want = want;
    seen = cells_taken;
    while (cells_taken == seen) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_signed();
    case ($urandom_range(6))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3, 4: return 32'($signed($urandom_range(2097152)) - 1048576);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_coeff();
    case ($urandom_range(6))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom_range(262144);
      default: return $urandom;
    endcase
  endfunction

  cell_row_t   directed [22];
  grid_setup_t phases [11];
  grid_setup_t g;
  cell_result_t none;
  int unsigned cells;

  initial begin
    none = '0;
    // after reset the grid is one cell, so each cell gives zero and grid_done
    directed[0] = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, '{32'h0, 10'd0, 16'd0, 1'b1}};
    directed[1] = '{32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b1, '{32'h0, 10'd0, 16'd0, 1'b1}};
    directed[2] = '{32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0, 10'd0, 16'd0, 1'b1}};
    directed[3] = '{32'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 10'd0, 16'd0, 1'b1}};
    // 3x3 dirichlet with residual, extreme steps and zero coefficients
    directed[4]  = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, none};
    directed[5]  = '{32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b0, none};
    directed[6]  = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0, none};
    directed[7]  = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 1'b0, none};
    directed[8]  = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, none};
    directed[9]  = '{32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b0, none};
    directed[10] = '{32'h0001_0000, 32'h0, 32'hFFFF_0000, 1'b0, none};
    directed[11] = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, none};
    directed[12] = '{32'h0, 32'h0, 32'h0, 1'b0, none};
    // 3x3 neumann, mirrored neighbours with uneven coefficients
    directed[13] = '{32'h0002_0000, 32'h0001_0000, 32'h1, 1'b0, none};
    directed[14] = '{32'hFFFE_0000, 32'h0004_0000, 32'h2, 1'b0, none};
    directed[15] = '{32'h0003_0000, 32'h0, 32'h3, 1'b0, none};
    directed[16] = '{32'h0005_8000, 32'h0002_0000, 32'h4, 1'b0, none};
    directed[17] = '{32'h7FFF_FFFF, 32'h0001_8000, 32'h5, 1'b0, none};
    directed[18] = '{32'h8000_0000, 32'h0000_0001, 32'h6, 1'b0, none};
    directed[19] = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h7, 1'b0, none};
    directed[20] = '{32'hFFFF_8000, 32'h0, 32'h8, 1'b0, none};
    directed[21] = '{32'h0000_4000, 32'h0003_0000, 32'h9, 1'b0, none};

    phases[0]  = '{5, 4, 32'd65536, 32'd65536, BND_DIRICHLET, 1'b0, 2};
    phases[1]  = '{4, 5, 32'h0002_0000, 32'h0000_8000, BND_NEUMANN, 1'b1, 2};
    phases[2]  = '{6, 3, $urandom, $urandom, BND_OPEN, 1'b0, 2};
    phases[3]  = '{3, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, BND_SPARE, 1'b1, 2};
    phases[4]  = '{0, 7, $urandom, $urandom, BND_DIRICHLET, 1'b1, 2};
    phases[5]  = '{8, 0, $urandom, $urandom, BND_DIRICHLET, 1'b0, 2};
    phases[6]  = '{2, 5, $urandom, $urandom, BND_NEUMANN, 1'b1, 2};
    phases[7]  = '{7, 6, 32'h0, 32'h0, BND_NEUMANN, 1'b0, 1};
    phases[8]  = '{2047, 1, 32'd65536, 32'd65536, BND_DIRICHLET, 1'b1, 1};
    phases[9]  = '{4, 4, $urandom, $urandom, BND_NEUMANN, 1'b1, 2};
    phases[10] = '{5, 5, $urandom_range(1 << 20), $urandom_range(1 << 20),
                   BND_DIRICHLET, 1'b0, 1};

    // hold reset low, then release it
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed cells
    stall_pct = 0;
    gap_pct = 0;
    for (int k = 0; k < 22; k++) begin
      if (k == 4) begin
        drain();
        apply_setup('{3, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, BND_DIRICHLET, 1'b1, 1});
      end else if (k == 13) begin
        drain();
        apply_setup('{3, 3, 32'd65536, 32'h0003_0000, BND_NEUMANN, 1'b0, 1});
      end
      send_cell(directed[k].pot, directed[k].nu, directed[k].src,
                directed[k].typed, directed[k].want);
    end
    drain();

    // random grids under each setting and idle pattern; a wide grid is cut
    // short, so the next setting restarts the counters from out of range
    foreach (phases[p]) begin
      g = phases[p];
      apply_setup(g);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 50; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 50; end
        default: begin gap_pct = 32; stall_pct = 32; end
      endcase
      cells = (g.w == 0 ? 1 : (g.w > BUF_W ? BUF_W : g.w)) * (g.h == 0 ? 1 : g.h);
      for (int n = 0; n < g.grids * cells && n < PHASE_CELLS; n++)
        send_cell(pick_signed(), pick_coeff(), pick_signed(), 1'b0, none);
      drain();
    end

    gap_pct = 0;
    stall_pct = 0;
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (pending_results.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
